>>> rtl/core/sra_pkg.sv
`default_nettype none

package sra_pkg;

    localparam int OP_W      = 2;
    localparam int WORD_W    = 28;
    localparam int CH_W      = 14;
    localparam int CNT_W     = 14;
    localparam int CH_LSB    = 14;
    localparam int PIX_W     = 16;
    localparam int RES_W     = 32;
    localparam int BIN_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 14;

    localparam int NUM_CHANNELS_DEF = 16384;
    localparam int ACC_WIDTH_DEF    = 32;

    localparam logic [RES_W-1:0] RES_MAX      = {RES_W{1'b1}};
    localparam logic [CH_W-1:0]  ROI_LOW_RST  = CH_W'(0);
    localparam logic [CH_W-1:0]  ROI_HI_RST   = CH_W'(16383);

    localparam logic [CFG_IDX_W-1:0] CFG_ROI_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_HI   = CFG_IDX_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_EVENT     = 2'd0,
        OP_PIXEL_END = 2'd1,
        OP_READ_BIN  = 2'd2
    } op_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_BIN   = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [PIX_W-1:0]   pixel_index;
        logic [RES_W-1:0]   total_integral;
        logic [RES_W-1:0]   roi_integral;
        logic [RES_W-1:0]   max_roi_integral;
        logic [BIN_W-1:0]   bin_value;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/sra_if.sv
`default_nettype none

interface sra_evt_if
    import sra_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [WORD_W-1:0]   event_word;
    logic [CH_W-1:0]     bin_index;

    modport source (output valid, output opcode, output event_word, output bin_index,
                    input ready);
    modport sink   (input valid, input opcode, input event_word, input bin_index,
                    output ready);
endinterface

interface sra_res_if
    import sra_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [PIX_W-1:0]    pixel_index;
    logic [RES_W-1:0]    total_integral;
    logic [RES_W-1:0]    roi_integral;
    logic [RES_W-1:0]    max_roi_integral;
    logic [BIN_W-1:0]    bin_value;

    modport source (output valid, output kind, output pixel_index, output total_integral,
                    output roi_integral, output max_roi_integral, output bin_value,
                    input ready);
    modport sink   (input valid, input kind, input pixel_index, input total_integral,
                    input roi_integral, input max_roi_integral, input bin_value,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/spectrum_roi_accumulator_top.sv
`default_nettype none

// channel  dir  beat contents
// evt      in   opcode, event_word, bin_index
// res      out  kind, pixel_index, total/roi/max_roi integrals, bin_value
// cfg      in   write enable, index, data (lower and upper ROI bound)
//
// One beat per cycle while evt.ready is high; a result enters the queue in the cycle after accept.
// The spectrum RAM is read on accept and written back in the cycle after,
// with a one-deep bypass for back-to-back hits on the same bin.
// After reset a clearing pass writes zero to all NUM_CHANNELS addresses
// (16384 by default) of the spectrum; evt.ready stays low throughout.
// Results sit in a three-entry queue; outside the clearing pass evt.ready drops only when it could fill.

module spectrum_roi_accumulator_top
    import sra_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int ACC_WIDTH    = ACC_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    sra_evt_if.sink                   evt,
    sra_res_if.source                 res,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int AW      = $clog2(NUM_CHANNELS);
    localparam int EXTW    = (ACC_WIDTH > RES_W) ? ACC_WIDTH : RES_W;
    localparam int QDEPTH  = 3;
    localparam int QPW     = 2;

    function automatic logic [RES_W-1:0] to_res(input logic [ACC_WIDTH-1:0] v);
        logic [EXTW-1:0] e;
        e = EXTW'(v);
        return (e > EXTW'(RES_MAX)) ? RES_MAX : e[RES_W-1:0];
    endfunction

    function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic [ACC_WIDTH-1:0] a,
                                                     input logic [CNT_W-1:0]     c);
        logic [ACC_WIDTH:0] s;
        s = {1'b0, a} + (ACC_WIDTH+1)'(c);
        return s[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : s[ACC_WIDTH-1:0];
    endfunction

    // configuration
    logic [CH_W-1:0] roi_lo_reg, roi_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roi_lo_reg <= ROI_LOW_RST;
            roi_hi_reg <= ROI_HI_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROI_LOW: roi_lo_reg <= cfg_data;
                CFG_ROI_HI:  roi_hi_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // stage 0: decode and issue RAM read
    op_t             in_op;
    logic [CH_W-1:0] in_ch, in_idx;
    logic [CNT_W-1:0] in_cnt;
    logic            accept;
    logic            clear_busy_reg;
    logic            q_room;

    assign in_op  = op_t'(evt.opcode);
    assign in_ch  = evt.event_word[CH_LSB +: CH_W];
    assign in_cnt = evt.event_word[CNT_W-1:0];
    assign in_idx = (in_op == OP_READ_BIN) ? evt.bin_index : in_ch;
    assign evt.ready = !clear_busy_reg && q_room;
    assign accept    = evt.valid && evt.ready;

    // stage 1 registers
    logic            s1_valid_reg;
    op_t             s1_op_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic            s1_hit_reg;
    logic            s1_roi_reg;
    logic [CNT_W-1:0] s1_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= in_op;
            s1_addr_reg <= in_idx[AW-1:0];
            s1_hit_reg  <= ({1'b0, in_idx} < (CH_W+1)'(NUM_CHANNELS));
            s1_roi_reg  <= (in_ch > roi_lo_reg) && (in_ch < roi_hi_reg);
            s1_cnt_reg  <= in_cnt;
        end
    end

    // spectrum RAM, clearing pass, bypass
    logic [AW-1:0]    clr_addr_reg;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [BIN_W-1:0] ram_wdata, ram_rdata;
    logic             fwd_valid_reg;
    logic [AW-1:0]    fwd_addr_reg;
    logic [BIN_W-1:0] fwd_data_reg;
    logic [BIN_W-1:0] bin_cur, bin_sat;
    logic [BIN_W:0]   bin_sum;

    sra_ram #(
        .WIDTH (BIN_W),
        .DEPTH (NUM_CHANNELS)
    ) u_spectrum (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign bin_cur = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg
                                                                        : ram_rdata;
    assign bin_sum = {1'b0, bin_cur} + (BIN_W+1)'(s1_cnt_reg);
    assign bin_sat = bin_sum[BIN_W] ? {BIN_W{1'b1}} : bin_sum[BIN_W-1:0];

    assign ram_we    = clear_busy_reg ||
                       (s1_valid_reg && (s1_op_reg == OP_EVENT) && s1_hit_reg);
    assign ram_waddr = clear_busy_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clear_busy_reg ? '0 : bin_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clr_addr_reg   <= '0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= ram_we;
            if (clear_busy_reg)
            begin
                if (clr_addr_reg == AW'(NUM_CHANNELS - 1))
                begin
                    clear_busy_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= ram_waddr;
        fwd_data_reg <= ram_wdata;
    end

    // pixel accumulators and result formation
    logic [ACC_WIDTH-1:0] total_acc_reg, total_acc_next;
    logic [ACC_WIDTH-1:0] roi_acc_reg, roi_acc_next;
    logic [ACC_WIDTH-1:0] max_roi_reg, max_roi_next;
    logic [PIX_W-1:0]     pixel_cnt_reg, pixel_cnt_next;
    result_t              s1_result;
    logic                 s1_push;

    always_comb
    begin
        total_acc_next = total_acc_reg;
        roi_acc_next   = roi_acc_reg;
        max_roi_next   = max_roi_reg;
        pixel_cnt_next = pixel_cnt_reg;
        s1_result      = '0;
        s1_push        = 1'b0;
        if (s1_valid_reg)
        begin
            case (s1_op_reg)
                OP_EVENT:
                begin
                    total_acc_next = sat_acc(total_acc_reg, s1_cnt_reg);
                    if (s1_roi_reg)
                    begin
                        roi_acc_next = sat_acc(roi_acc_reg, s1_cnt_reg);
                    end
                end
                OP_PIXEL_END:
                begin
                    if (roi_acc_reg > max_roi_reg)
                    begin
                        max_roi_next = roi_acc_reg;
                    end
                    s1_result.kind             = KIND_PIXEL;
                    s1_result.pixel_index      = pixel_cnt_reg;
                    s1_result.total_integral   = to_res(total_acc_reg);
                    s1_result.roi_integral     = to_res(roi_acc_reg);
                    s1_result.max_roi_integral = to_res(max_roi_next);
                    s1_push        = 1'b1;
                    total_acc_next = '0;
                    roi_acc_next   = '0;
                    pixel_cnt_next = pixel_cnt_reg + PIX_W'(1);
                end
                OP_READ_BIN:
                begin
                    s1_result.kind      = KIND_BIN;
                    s1_result.bin_value = s1_hit_reg ? bin_cur : '0;
                    s1_push             = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_acc_reg <= '0;
            roi_acc_reg   <= '0;
            max_roi_reg   <= '0;
            pixel_cnt_reg <= '0;
        end
        else
        begin
            total_acc_reg <= total_acc_next;
            roi_acc_reg   <= roi_acc_next;
            max_roi_reg   <= max_roi_next;
            pixel_cnt_reg <= pixel_cnt_next;
        end
    end

    // result queue
    result_t          q_mem_reg [QDEPTH];
    logic [QPW-1:0]   q_wr_reg, q_rd_reg, q_cnt_reg, q_cnt_next;
    logic             q_pop;
    result_t          q_head;

    assign q_room  = (QPW'(q_cnt_reg) + QPW'(s1_push)) < QPW'(QDEPTH);
    assign q_pop   = res.valid && res.ready;
    assign q_head  = q_mem_reg[q_rd_reg];
    assign q_cnt_next = q_cnt_reg + QPW'(s1_push) - QPW'(q_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (s1_push)
            begin
                q_wr_reg <= (q_wr_reg == QPW'(QDEPTH - 1)) ? '0 : q_wr_reg + QPW'(1);
            end
            if (q_pop)
            begin
                q_rd_reg <= (q_rd_reg == QPW'(QDEPTH - 1)) ? '0 : q_rd_reg + QPW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_push)
        begin
            q_mem_reg[q_wr_reg] <= s1_result;
        end
    end

    assign res.valid            = (q_cnt_reg != '0);
    assign res.kind             = q_head.kind;
    assign res.pixel_index      = q_head.pixel_index;
    assign res.total_integral   = q_head.total_integral;
    assign res.roi_integral     = q_head.roi_integral;
    assign res.max_roi_integral = q_head.max_roi_integral;
    assign res.bin_value        = q_head.bin_value;

endmodule

`default_nettype wire

>>> rtl/core/sra_ram.sv
`default_nettype none

module sra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read at the written address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sra_checker.sv
`default_nettype none

module sra_checker
    import sra_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             evt_ready,
    input wire logic             res_valid,
    input wire logic             res_ready,
    input wire logic             res_kind,
    input wire logic [PIX_W-1:0] res_pixel_index,
    input wire logic [RES_W-1:0] res_total_integral,
    input wire logic [RES_W-1:0] res_roi_integral,
    input wire logic [RES_W-1:0] res_max_roi_integral,
    input wire logic [BIN_W-1:0] res_bin_value
);

    // spectrum clear runs straight after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !evt_ready)
        else $error("evt.ready high during spectrum clear");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    a_bin_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_BIN) |->
            (res_pixel_index == '0) && (res_total_integral == '0) &&
            (res_roi_integral == '0) && (res_max_roi_integral == '0))
        else $error("bin read carries pixel fields");

    a_pixel_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_PIXEL) |->
            (res_bin_value == '0) && (res_max_roi_integral >= res_roi_integral))
        else $error("pixel summary inconsistent");

endmodule

bind spectrum_roi_accumulator_top sra_checker u_sra_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .evt_ready            (evt.ready),
    .res_valid            (res.valid),
    .res_ready            (res.ready),
    .res_kind             (res.kind),
    .res_pixel_index      (res.pixel_index),
    .res_total_integral   (res.total_integral),
    .res_roi_integral     (res.roi_integral),
    .res_max_roi_integral (res.max_roi_integral),
    .res_bin_value        (res.bin_value)
);

`default_nettype wire

>>> verif/tb_spectrum_roi_accumulator_top.sv
`default_nettype none

module tb_spectrum_roi_accumulator_top;
    import sra_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int CH_TOP = NUM_CHANNELS_DEF - 1;

    class roi_scoreboard;
        bit [BIN_W-1:0] spectrum [NUM_CHANNELS_DEF];
        bit [RES_W-1:0] total_acc;
        bit [RES_W-1:0] roi_acc;
        bit [RES_W-1:0] max_roi;
        bit [PIX_W-1:0] pixel_count;
        bit [CH_W-1:0]  roi_lo;
        bit [CH_W-1:0]  roi_hi;
        result_t        expected_q[$];
        int             mismatches;

        function new();
            total_acc   = '0;
            roi_acc     = '0;
            max_roi     = '0;
            pixel_count = '0;
            roi_lo      = ROI_LOW_RST;
            roi_hi      = ROI_HI_RST;
            mismatches  = 0;
        endfunction

        function bit [RES_W-1:0] sat_sum(bit [RES_W-1:0] a, bit [RES_W-1:0] b);
            bit [RES_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[RES_W] ? RES_MAX : s[RES_W-1:0];
        endfunction

        function void note_beat(logic [OP_W-1:0] op, logic [WORD_W-1:0] word,
                                logic [CH_W-1:0] idx);
            bit [CH_W-1:0]  ch;
            bit [RES_W-1:0] cnt;
            result_t        e;
            ch  = word[CH_LSB +: CH_W];
            cnt = RES_W'(word[CNT_W-1:0]);
            e   = '0;
            if (op == OP_EVENT)
            begin
                spectrum[ch] = sat_sum(spectrum[ch], cnt);
                total_acc    = sat_sum(total_acc, cnt);
                if (ch > roi_lo && ch < roi_hi)
                    roi_acc = sat_sum(roi_acc, cnt);
            end
            else if (op == OP_PIXEL_END)
            begin
                if (roi_acc > max_roi)
                    max_roi = roi_acc;
                e.kind             = KIND_PIXEL;
                e.pixel_index      = pixel_count;
                e.total_integral   = total_acc;
                e.roi_integral     = roi_acc;
                e.max_roi_integral = max_roi;
                expected_q.insert(expected_q.size(), e);
                total_acc   = '0;
                roi_acc     = '0;
                pixel_count = pixel_count + 1'b1;
            end
            else if (op == OP_READ_BIN)
            begin
                e.kind      = KIND_BIN;
                e.bin_value = spectrum[idx];
                expected_q.insert(expected_q.size(), e);
            end
        endfunction

        function void compare_field(string name, longint unsigned exp_v,
                                    longint unsigned got_v);
            if (exp_v != got_v)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected %0h, got %0h", name, exp_v, got_v);
            end
        endfunction

        function void check_beat(result_t got);
            result_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: kind %0d bin_value %0h",
                             got.kind, got.bin_value);
                return;
            end
            e = expected_q.pop_front();
            compare_field("kind", e.kind, got.kind);
            compare_field("pixel_index", e.pixel_index, got.pixel_index);
            compare_field("total_integral", e.total_integral, got.total_integral);
            compare_field("roi_integral", e.roi_integral, got.roi_integral);
            compare_field("max_roi_integral", e.max_roi_integral, got.max_roi_integral);
            compare_field("bin_value", e.bin_value, got.bin_value);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    bit                 steady;
    int                 last_ch;
    roi_scoreboard      sb;

    sra_evt_if evt_bus ();
    sra_res_if res_bus ();

    spectrum_roi_accumulator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("spectrum_roi_accumulator_top regression: fail");
        $finish;
    end

    // result side: check on the beat, then pick next ready
    initial
    begin
        result_t got;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
            begin
                got.kind             = kind_t'(res_bus.kind);
                got.pixel_index      = res_bus.pixel_index;
                got.total_integral   = res_bus.total_integral;
                got.roi_integral     = res_bus.roi_integral;
                got.max_roi_integral = res_bus.max_roi_integral;
                got.bin_value        = res_bus.bin_value;
                sb.check_beat(got);
            end
            res_bus.ready <= steady || ($urandom_range(99) >= 34);
        end
    end

    function automatic int clamp_ch(int v);
        return (v < 0) ? 0 : ((v > CH_TOP) ? CH_TOP : v);
    endfunction

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                             input logic [CH_W-1:0] idx);
        while (!steady && $urandom_range(99) < 34)
        begin
            evt_bus.valid <= 1'b0;
            @(posedge clk);
        end
        evt_bus.valid      <= 1'b1;
        evt_bus.opcode     <= op;
        evt_bus.event_word <= word;
        evt_bus.bin_index  <= idx;
        do
            @(posedge clk);
        while (!evt_bus.ready);
        sb.note_beat(op, word, idx);
    endtask

    task automatic send_event(input int ch, input int cnt);
        last_ch = ch;
        send_beat(OP_EVENT, {CH_W'(ch), CNT_W'(cnt)}, '0);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        evt_bus.valid <= 1'b0;
        while (sb.pending() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_roi(input int lo, input int hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROI_LOW;
        cfg_data  <= CFG_W'(lo);
        @(posedge clk);
        cfg_index <= CFG_ROI_HI;
        cfg_data  <= CFG_W'(hi);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.roi_lo = CH_W'(lo);
        sb.roi_hi = CH_W'(hi);
    endtask

    task automatic run_random(input int n);
        int counted;
        int r;
        int ch;
        int cnt;
        counted = 0;
        while (counted < n)
        begin
            r = $urandom_range(99);
            if (r < 68)
            begin
                r = $urandom_range(99);
                if (r < 40)
                    ch = clamp_ch(((r < 20) ? int'(sb.roi_lo) : int'(sb.roi_hi))
                                  + int'($urandom_range(2)) - 1);
                else if (r < 60)
                    ch = (r < 50) ? last_ch : 77;
                else
                    ch = $urandom_range(CH_TOP);
                r = $urandom_range(99);
                cnt = (r < 10) ? 0 : ((r < 20) ? 16383 : int'($urandom_range(16383)));
                send_event(ch, cnt);
                counted++;
            end
            else if (r < 82)
            begin
                send_beat(OP_PIXEL_END, WORD_W'($urandom), CH_W'($urandom));
                counted++;
            end
            else if (r < 97)
            begin
                ch = ($urandom_range(1) == 0) ? last_ch : int'($urandom_range(CH_TOP));
                send_beat(OP_READ_BIN, WORD_W'($urandom), CH_W'(ch));
                counted++;
            end
            else
                send_beat(OP_SPARE, WORD_W'($urandom), CH_W'($urandom));
        end
    endtask

    initial
    begin
        int lo_set [6];
        int hi_set [6];
        int failures;
        sb = new();
        lo_set = '{0, 16383, 5000, 5000, 0, 0};
        hi_set = '{16383, 0, 5001, 5002, 0, 0};
        lo_set[5] = $urandom_range(CH_TOP);
        hi_set[5] = $urandom_range(CH_TOP);
        steady  = 1'b0;
        last_ch = 0;
        rst_n   = 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_ROI_LOW;
        cfg_data           <= '0;
        evt_bus.valid      <= 1'b0;
        evt_bus.opcode     <= OP_EVENT;
        evt_bus.event_word <= '0;
        evt_bus.bin_index  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // spectrum clear pass holds ready low
        do
            @(posedge clk);
        while (!evt_bus.ready);

        // directed, reset ROI bounds
        send_beat(OP_PIXEL_END, '0, '0);
        send_event(0, 16383);
        send_event(CH_TOP, 16383);
        send_event(1, 1);
        send_event(16382, 'h2AAA);
        send_event('h1555, 'h1555);
        send_event('h2AAA, 0);
        send_event(1, 5);
        send_event(1, 7);
        send_beat(OP_READ_BIN, '0, CH_W'(1));
        send_beat(OP_READ_BIN, '1, CH_W'(0));
        send_beat(OP_READ_BIN, '0, CH_W'(CH_TOP));
        send_beat(OP_SPARE, '1, '1);
        send_beat(OP_PIXEL_END, '1, '1);
        send_beat(OP_READ_BIN, '0, CH_W'(16382));
        send_beat(OP_PIXEL_END, '0, '0);
        send_beat(OP_READ_BIN, '0, CH_W'('h1555));
        send_beat(OP_READ_BIN, '0, CH_W'('h2AAA));
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_roi(lo_set[p], hi_set[p]);
            steady = (p == 3);
            run_random(90);
            drain();
        end

        // narrow ROI with a single channel inside
        write_roi(9000, 9002);
        send_event(9001, 16383);
        send_beat(OP_READ_BIN, '0, CH_W'(9001));
        send_beat(OP_PIXEL_END, '0, '0);
        send_event(9001, 1);
        send_event(9000, 3);
        send_beat(OP_READ_BIN, '0, CH_W'(9001));
        send_beat(OP_PIXEL_END, '0, '0);
        drain();

        failures = sb.mismatches + sb.pending();
        if (failures == 0)
            $display("spectrum_roi_accumulator_top regression: pass");
        else
            $display("spectrum_roi_accumulator_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
